/* hw/rtl/rtspp_pkg.sv */
// Package: shared types, phase codes and literal tables of the RTSP request parser.
package rtspp_pkg;

  localparam int HostNameMax = 64;
  localparam int PathNameMax = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  name_char;
    logic [5:0]  name_index;
    logic [2:0]  status;
    logic [2:0]  method;
    logic [31:0] sequence_number;
    logic [31:0] body_length;
    logic        tcp_transport;
    logic [15:0] client_rtp_port;
    logic [16:0] client_rtcp_port;
  } out_item_t;

  typedef enum logic [30:0] {
    PH_LEAD      = 31'h0000_0001,
    PH_LEAD_LF   = 31'h0000_0002,
    PH_METHOD    = 31'h0000_0004,
    PH_WS1       = 31'h0000_0008,
    PH_SCHEME    = 31'h0000_0010,
    PH_HOST      = 31'h0000_0020,
    PH_SLASH1    = 31'h0000_0040,
    PH_PRES      = 31'h0000_0080,
    PH_SLASH2    = 31'h0000_0100,
    PH_STREAM    = 31'h0000_0200,
    PH_SLASH3    = 31'h0000_0400,
    PH_WS2       = 31'h0000_0800,
    PH_VERSION   = 31'h0000_1000,
    PH_VMAJ      = 31'h0000_2000,
    PH_VDOT      = 31'h0000_4000,
    PH_VMIN      = 31'h0000_8000,
    PH_SKIP      = 31'h0001_0000,
    PH_SKIP_CR   = 31'h0002_0000,
    PH_LINE      = 31'h0004_0000,
    PH_NUM_WS    = 31'h0008_0000,
    PH_NUM_DIG   = 31'h0010_0000,
    PH_T_WS      = 31'h0020_0000,
    PH_T_PROFILE = 31'h0040_0000,
    PH_T_TCP     = 31'h0080_0000,
    PH_T_PSKIP   = 31'h0100_0000,
    PH_T_PNAME   = 31'h0200_0000,
    PH_T_PORT    = 31'h0400_0000,
    PH_T_SEG     = 31'h0800_0000,
    PH_T_CR      = 31'h1000_0000,
    PH_T_EOL     = 31'h2000_0000,
    PH_SINK      = 31'h4000_0000
  } phase_t;

  localparam logic [1:0] KIND_HOST    = 2'd0;
  localparam logic [1:0] KIND_PRES    = 2'd1;
  localparam logic [1:0] KIND_STREAM  = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_METHOD    = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam logic [2:0] M_NONE     = 3'd0;
  localparam logic [2:0] M_OPTIONS  = 3'd1;
  localparam logic [2:0] M_DESCRIBE = 3'd2;
  localparam logic [2:0] M_SETUP    = 3'd3;
  localparam logic [2:0] M_PLAY     = 3'd4;
  localparam logic [2:0] M_TEARDOWN = 3'd5;

  // Header name selectors.
  localparam logic [1:0] HD_CSEQ      = 2'd0;
  localparam logic [1:0] HD_LENGTH    = 2'd1;
  localparam logic [1:0] HD_TRANSPORT = 2'd2;

  // Short literal selectors.
  localparam int LIT_SCHEME  = 0;
  localparam int LIT_VERSION = 1;
  localparam int LIT_PROFILE = 2;
  localparam int LIT_TCP     = 3;
  localparam int LIT_PORT    = 4;

  // Method text including trailing space; zero past the end.
  function automatic logic [7:0] method_chr(input logic [2:0] m, input logic [4:0] i);
    string s;
    case (m)
      M_OPTIONS:  s = "OPTIONS ";
      M_DESCRIBE: s = "DESCRIBE ";
      M_SETUP:    s = "SETUP ";
      M_PLAY:     s = "PLAY ";
      M_TEARDOWN: s = "TEARDOWN ";
      default:    s = "";
    endcase
    return (int'(i) < s.len()) ? 8'(s[i]) : 8'd0;
  endfunction

  function automatic logic [4:0] method_len(input logic [2:0] m);
    case (m)
      M_OPTIONS:  return 5'd8;
      M_DESCRIBE: return 5'd9;
      M_SETUP:    return 5'd6;
      M_PLAY:     return 5'd5;
      M_TEARDOWN: return 5'd9;
      default:    return 5'd0;
    endcase
  endfunction

  // Header name text: CSeq:, Content-Length:, Transport:
  function automatic logic [7:0] head_chr(input logic [1:0] h, input logic [4:0] i);
    string s;
    case (h)
      HD_CSEQ:   s = "CSeq:";
      HD_LENGTH: s = "Content-Length:";
      default:   s = "Transport:";
    endcase
    return (int'(i) < s.len()) ? 8'(s[i]) : 8'd0;
  endfunction

  function automatic logic [4:0] head_len(input logic [1:0] h);
    case (h)
      HD_CSEQ:   return 5'd5;
      HD_LENGTH: return 5'd15;
      default:   return 5'd10;
    endcase
  endfunction

  // Short literals indexed by offset.
  function automatic logic [7:0] lit_chr(input int sel, input logic [4:0] i);
    string s;
    case (sel)
      LIT_SCHEME:  s = "rtsp://";
      LIT_VERSION: s = "RTSP/";
      LIT_PROFILE: s = "RTP/AVP";
      LIT_TCP:     s = "/TCP";
      default:     s = {"client_", "port="};
    endcase
    return (int'(i) < s.len()) ? 8'(s[i]) : 8'd0;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

/* hw/rtl/rtsp_request_parser.sv */
// Top level: byte-wide RTSP request parser with a registered result stage.
//
//  channel | ports                      | moves
//  in      | in_valid in_ready in_data  | one request byte per transfer
//  out     | out_valid out_ready out_data | name byte or final summary
//
// One byte per cycle: the parse FSM steps once per accepted byte. The next-phase
// logic runs up to three passes in that cycle, so a byte that ends one phase is
// re-examined by the next (end of a Transport line, header match, line skip).
// A result appears in the cycle after its byte. Input is stalled only when the
// result register is full and not being taken. Reset is synchronous; it
// returns the parser to the start of a request line.
module rtsp_request_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtspp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rtspp_pkg::out_item_t out_data
);

  rtspp_pkg::phase_t ph_r, ph_nxt, fold_r, fold_nxt;
  logic [4:0]  off_r, off_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  meth_r, meth_nxt, guess_r, guess_nxt;
  logic [31:0] seq_r, seq_nxt, len_r, len_nxt;
  logic        tcp_r, tcp_nxt, tgt_r, tgt_nxt, dig_r, dig_nxt;
  logic [15:0] port_r, port_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [2:0]  hmask_r, hmask_nxt;

  logic        emit;
  logic [1:0]  emit_kind;
  logic [5:0]  emit_idx;
  logic        fire;
  rtspp_pkg::out_item_t res;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // Multiply-by-ten with saturation against a cap.
  function automatic logic [31:0] add_dig32(input logic [31:0] a, input logic [3:0] d);
    logic [35:0] t;
    t = {4'd0, a} * 36'd10 + {32'd0, d};
    return (t[35:32] != 4'd0) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic logic [31:0] add_dig16(input logic [31:0] a, input logic [3:0] d);
    logic [20:0] t;
    t = 21'(a[15:0]) * 21'd10 + 21'(d);
    return (t > 21'd65535) ? 32'd65535 : {11'd0, t};
  endfunction

  // Next-state: phase logic, repeated for phases that re-examine the byte.
  always_comb begin
    logic [7:0] c;
    logic [7:0] lc;
    logic       again;
    logic [2:0] keep;
    logic [4:0] o1;
    c = in_data.data_byte;
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    ph_nxt = ph_r; fold_nxt = fold_r; off_nxt = off_r; cnt_nxt = cnt_r;
    acc_nxt = acc_r; meth_nxt = meth_r; guess_nxt = guess_r; seq_nxt = seq_r;
    len_nxt = len_r; tcp_nxt = tcp_r; tgt_nxt = tgt_r; dig_nxt = dig_r;
    port_nxt = port_r; err_nxt = err_r; hmask_nxt = hmask_r;
    emit = 1'b0; emit_kind = rtspp_pkg::KIND_HOST; emit_idx = '0;
    again = 1'b1;
    keep = '0;
    o1 = '0;
    for (int pass = 0; pass < 3; pass++) begin
      if (again) begin
        again = 1'b0;
        case (ph_nxt)
          rtspp_pkg::PH_LEAD: begin
            if (c == 8'h0d) ph_nxt = rtspp_pkg::PH_LEAD_LF;
            else begin ph_nxt = rtspp_pkg::PH_METHOD; off_nxt = '0; again = 1'b1; end
          end
          rtspp_pkg::PH_LEAD_LF: begin
            if (c == 8'h0a) begin ph_nxt = rtspp_pkg::PH_METHOD; off_nxt = '0; end
            else begin err_nxt = rtspp_pkg::ST_METHOD; ph_nxt = rtspp_pkg::PH_SINK; end
          end
          rtspp_pkg::PH_METHOD: begin
            if (off_nxt == 5'd0) begin
              case (c)
                8'h4f:   guess_nxt = rtspp_pkg::M_OPTIONS;
                8'h44:   guess_nxt = rtspp_pkg::M_DESCRIBE;
                8'h53:   guess_nxt = rtspp_pkg::M_SETUP;
                8'h50:   guess_nxt = rtspp_pkg::M_PLAY;
                8'h54:   guess_nxt = rtspp_pkg::M_TEARDOWN;
                default: guess_nxt = rtspp_pkg::M_NONE;
              endcase
            end
            if (guess_nxt == rtspp_pkg::M_NONE ||
                c != rtspp_pkg::method_chr(guess_nxt, off_nxt)) begin
              err_nxt = rtspp_pkg::ST_METHOD; ph_nxt = rtspp_pkg::PH_SINK;
            end else begin
              off_nxt = off_nxt + 5'd1;
              if (off_nxt == rtspp_pkg::method_len(guess_nxt)) begin
                meth_nxt = guess_nxt; ph_nxt = rtspp_pkg::PH_WS1;
              end
            end
          end
          rtspp_pkg::PH_WS1: begin
            if (!rtspp_pkg::is_space(c)) begin
              ph_nxt = rtspp_pkg::PH_SCHEME; off_nxt = '0; again = 1'b1;
            end
          end
          rtspp_pkg::PH_SCHEME: begin
            if (lc != rtspp_pkg::lit_chr(rtspp_pkg::LIT_SCHEME, off_nxt)) begin
              err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK;
            end else begin
              off_nxt = off_nxt + 5'd1;
              if (off_nxt == 5'd7) begin ph_nxt = rtspp_pkg::PH_HOST; cnt_nxt = '0; end
            end
          end
          rtspp_pkg::PH_HOST, rtspp_pkg::PH_PRES, rtspp_pkg::PH_STREAM: begin
            if (c == 8'h2f) begin
              ph_nxt = (ph_nxt == rtspp_pkg::PH_HOST) ? rtspp_pkg::PH_SLASH1 :
                       (ph_nxt == rtspp_pkg::PH_PRES) ? rtspp_pkg::PH_SLASH2 :
                       rtspp_pkg::PH_SLASH3;
            end else if (ph_nxt == rtspp_pkg::PH_STREAM && (c == 8'h20 || c == 8'h09)) begin
              ph_nxt = rtspp_pkg::PH_WS2;
            end else if (rtspp_pkg::is_space(c)) begin
              err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK;
            end else if (cnt_nxt >= ((ph_nxt == rtspp_pkg::PH_HOST) ?
                         7'(rtspp_pkg::HostNameMax) : 7'(rtspp_pkg::PathNameMax))) begin
              err_nxt = rtspp_pkg::ST_TOO_LONG; ph_nxt = rtspp_pkg::PH_SINK;
            end else begin
              emit = 1'b1;
              emit_kind = (ph_nxt == rtspp_pkg::PH_HOST) ? rtspp_pkg::KIND_HOST :
                          (ph_nxt == rtspp_pkg::PH_PRES) ? rtspp_pkg::KIND_PRES :
                          rtspp_pkg::KIND_STREAM;
              emit_idx = cnt_nxt[5:0];
              cnt_nxt = cnt_nxt + 7'd1;
            end
          end
          rtspp_pkg::PH_SLASH1: begin
            if (c != 8'h2f) begin
              ph_nxt = rtspp_pkg::PH_PRES; cnt_nxt = '0; again = 1'b1;
            end
          end
          rtspp_pkg::PH_SLASH2: begin
            if (c != 8'h2f) begin
              ph_nxt = rtspp_pkg::PH_STREAM; cnt_nxt = '0; again = 1'b1;
            end
          end
          rtspp_pkg::PH_SLASH3: begin
            if (c == 8'h20 || c == 8'h09) ph_nxt = rtspp_pkg::PH_WS2;
            else if (c != 8'h2f) begin
              err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK;
            end
          end
          rtspp_pkg::PH_WS2: begin
            if (!rtspp_pkg::is_space(c)) begin
              ph_nxt = rtspp_pkg::PH_VERSION; off_nxt = '0; again = 1'b1;
            end
          end
          rtspp_pkg::PH_VERSION: begin
            if (c != rtspp_pkg::lit_chr(rtspp_pkg::LIT_VERSION, off_nxt)) begin
              err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK;
            end else begin
              off_nxt = off_nxt + 5'd1;
              if (off_nxt == 5'd5) ph_nxt = rtspp_pkg::PH_VMAJ;
            end
          end
          rtspp_pkg::PH_VMAJ, rtspp_pkg::PH_VMIN: begin
            if (rtspp_pkg::is_digit(c))
              ph_nxt = (ph_nxt == rtspp_pkg::PH_VMAJ) ? rtspp_pkg::PH_VDOT : rtspp_pkg::PH_SKIP;
            else begin err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK; end
          end
          rtspp_pkg::PH_VDOT: begin
            if (c == 8'h2e) ph_nxt = rtspp_pkg::PH_VMIN;
            else begin err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK; end
          end
          rtspp_pkg::PH_SKIP: begin
            if (c == 8'h0d) ph_nxt = rtspp_pkg::PH_SKIP_CR;
          end
          rtspp_pkg::PH_SKIP_CR: begin
            if (c == 8'h0a) begin
              ph_nxt = rtspp_pkg::PH_LINE; off_nxt = '0;
              hmask_nxt = {meth_nxt == rtspp_pkg::M_SETUP, 2'b11};
            end else if (c != 8'h0d) ph_nxt = rtspp_pkg::PH_SKIP;
          end
          rtspp_pkg::PH_LINE: begin
            for (int h = 0; h < 3; h++)
              keep[h] = hmask_nxt[h] && off_nxt < rtspp_pkg::head_len(2'(h)) &&
                        rtspp_pkg::head_chr(2'(h), off_nxt) == c;
            if (keep == 3'd0) begin
              ph_nxt = rtspp_pkg::PH_SKIP; again = 1'b1;
            end else begin
              hmask_nxt = keep;
              o1 = off_nxt + 5'd1;
              off_nxt = o1;
              for (int h = 0; h < 3; h++) begin
                if (keep[h] && rtspp_pkg::head_len(2'(h)) == o1) begin
                  if (2'(h) != rtspp_pkg::HD_TRANSPORT) begin
                    tgt_nxt = 1'(h); ph_nxt = rtspp_pkg::PH_NUM_WS;
                  end else begin
                    port_nxt = '0; ph_nxt = rtspp_pkg::PH_T_WS;
                  end
                end
              end
            end
          end
          rtspp_pkg::PH_NUM_WS: begin
            if (c != 8'h20 && c != 8'h09) begin
              if (rtspp_pkg::is_digit(c)) begin
                acc_nxt = {28'd0, c[3:0]}; ph_nxt = rtspp_pkg::PH_NUM_DIG;
              end else begin err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK; end
            end
          end
          rtspp_pkg::PH_NUM_DIG: begin
            if (rtspp_pkg::is_digit(c)) acc_nxt = add_dig32(acc_nxt, c[3:0]);
            else begin
              if (!tgt_nxt) seq_nxt = acc_nxt; else len_nxt = acc_nxt;
              ph_nxt = rtspp_pkg::PH_SKIP; again = 1'b1;
            end
          end
          rtspp_pkg::PH_T_WS: begin
            if (!rtspp_pkg::is_space(c)) begin
              ph_nxt = rtspp_pkg::PH_T_PROFILE; off_nxt = '0; again = 1'b1;
            end
          end
          rtspp_pkg::PH_T_PROFILE: begin
            if (c != rtspp_pkg::lit_chr(rtspp_pkg::LIT_PROFILE, off_nxt)) begin
              err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK;
            end else begin
              off_nxt = off_nxt + 5'd1;
              if (off_nxt == 5'd7) begin
                tcp_nxt = 1'b0; ph_nxt = rtspp_pkg::PH_T_TCP; off_nxt = '0;
              end
            end
          end
          rtspp_pkg::PH_T_TCP: begin
            if (c == rtspp_pkg::lit_chr(rtspp_pkg::LIT_TCP, off_nxt)) begin
              off_nxt = off_nxt + 5'd1;
              if (off_nxt == 5'd4) begin tcp_nxt = 1'b1; ph_nxt = rtspp_pkg::PH_T_PSKIP; end
            end else begin
              ph_nxt = (off_nxt == 5'd0) ? rtspp_pkg::PH_T_PSKIP : rtspp_pkg::PH_T_SEG;
              again = 1'b1;
            end
          end
          rtspp_pkg::PH_T_PSKIP: begin
            if (c == 8'h0d) begin
              fold_nxt = rtspp_pkg::PH_T_PSKIP; ph_nxt = rtspp_pkg::PH_T_CR;
            end else if (c != 8'h3b && c != 8'h20 && c != 8'h09) begin
              ph_nxt = rtspp_pkg::PH_T_PNAME; off_nxt = '0; again = 1'b1;
            end
          end
          rtspp_pkg::PH_T_PNAME: begin
            if (c == rtspp_pkg::lit_chr(rtspp_pkg::LIT_PORT, off_nxt)) begin
              off_nxt = off_nxt + 5'd1;
              if (off_nxt == 5'd12) begin
                ph_nxt = rtspp_pkg::PH_T_PORT; acc_nxt = '0; dig_nxt = 1'b0;
              end
            end else begin ph_nxt = rtspp_pkg::PH_T_SEG; again = 1'b1; end
          end
          rtspp_pkg::PH_T_PORT: begin
            if (rtspp_pkg::is_digit(c)) begin
              acc_nxt = add_dig16(acc_nxt, c[3:0]); dig_nxt = 1'b1;
            end else if (!dig_nxt) begin
              err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK;
            end else begin
              port_nxt = acc_nxt[15:0]; ph_nxt = rtspp_pkg::PH_T_SEG; again = 1'b1;
            end
          end
          rtspp_pkg::PH_T_SEG: begin
            if (c == 8'h3b) ph_nxt = rtspp_pkg::PH_T_PSKIP;
            else if (c == 8'h0d) begin
              fold_nxt = rtspp_pkg::PH_T_SEG; ph_nxt = rtspp_pkg::PH_T_CR;
            end
          end
          rtspp_pkg::PH_T_CR: begin
            if (c == 8'h0a) ph_nxt = rtspp_pkg::PH_T_EOL;
            else begin err_nxt = rtspp_pkg::ST_MALFORMED; ph_nxt = rtspp_pkg::PH_SINK; end
          end
          rtspp_pkg::PH_T_EOL: begin
            if (c == 8'h20 || c == 8'h09) ph_nxt = fold_nxt;
            else begin
              ph_nxt = rtspp_pkg::PH_LINE; off_nxt = '0;
              hmask_nxt = {meth_nxt == rtspp_pkg::M_SETUP, 2'b11};
              again = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result assembly.
  always_comb begin
    res = '0;
    if (in_data.last_byte) begin
      res.result_kind = rtspp_pkg::KIND_SUMMARY;
      if (err_nxt != rtspp_pkg::ST_OK) res.status = err_nxt;
      else if ((ph_nxt == rtspp_pkg::PH_LINE && off_nxt == 5'd0) ||
               ph_nxt == rtspp_pkg::PH_T_EOL) res.status = rtspp_pkg::ST_OK;
      else res.status = rtspp_pkg::ST_TRUNC;
      res.method = meth_nxt;
      res.sequence_number = seq_nxt;
      res.body_length = len_nxt;
      res.tcp_transport = tcp_nxt;
      res.client_rtp_port = port_nxt;
      res.client_rtcp_port = {1'b0, port_nxt} + 17'd1;
    end else begin
      res.result_kind = emit_kind;
      res.name_char = in_data.data_byte;
      res.name_index = emit_idx;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && in_data.last_byte)) begin
      ph_r <= rtspp_pkg::PH_LEAD; fold_r <= rtspp_pkg::PH_T_PSKIP;
      off_r <= '0; cnt_r <= '0; acc_r <= '0; meth_r <= '0; guess_r <= '0;
      seq_r <= '0; len_r <= '0; tcp_r <= 1'b0; tgt_r <= 1'b0; dig_r <= 1'b0;
      port_r <= '0; err_r <= '0; hmask_r <= '0;
    end else if (fire) begin
      ph_r <= ph_nxt; fold_r <= fold_nxt; off_r <= off_nxt; cnt_r <= cnt_nxt;
      acc_r <= acc_nxt; meth_r <= meth_nxt; guess_r <= guess_nxt; seq_r <= seq_nxt;
      len_r <= len_nxt; tcp_r <= tcp_nxt; tgt_r <= tgt_nxt; dig_r <= dig_nxt;
      port_r <= port_nxt; err_r <= err_nxt; hmask_r <= hmask_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (fire) out_valid <= emit || in_data.last_byte;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= res;
  end

endmodule

/* hw/rtl/rtspp_checker.sv */
// Checker: port-level assertions for the RTSP request parser, bound to the top.
module rtspp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input rtspp_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input rtspp_pkg::out_item_t out_data
);

  // Held result stays put while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // Input is open whenever the result register can drain.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled with free output");

  // A last byte always produces a summary next cycle.
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_byte |=>
      out_valid && out_data.result_kind == rtspp_pkg::KIND_SUMMARY)
    else $error("missing summary");

  // Name results carry zeroed summary fields.
  a_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != rtspp_pkg::KIND_SUMMARY |->
      out_data.status == rtspp_pkg::ST_OK && out_data.sequence_number == 32'd0)
    else $error("name result with summary data");

endmodule

bind rtsp_request_parser rtspp_checker u_rtspp_checker (.*);
